// ===== rtl/exlx_pkg.sv =====
// ----------------------------------------------------------------------------
// exlx_pkg
// shared types and codes of the expression lexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package exlx_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LINE_W        = 16;
  localparam int MAX_RECS      = 5;
  localparam int REC_IDX_W     = $clog2(MAX_RECS);
  localparam int REC_CNT_W     = $clog2(MAX_RECS + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REC_TEXT      = 2'd0;
  localparam logic [1:0] REC_TOKEN_END = 2'd1;
  localparam logic [1:0] REC_END_INPUT = 2'd2;
  localparam logic [1:0] REC_ERROR     = 2'd3;

  localparam logic [2:0] TOK_NUMBER   = 3'd0;
  localparam logic [2:0] TOK_IDENT    = 3'd1;
  localparam logic [2:0] TOK_STRING   = 3'd2;
  localparam logic [2:0] TOK_OPERATOR = 3'd3;
  localparam logic [2:0] TOK_LPAREN   = 3'd4;
  localparam logic [2:0] TOK_RPAREN   = 3'd5;
  localparam logic [2:0] TOK_COMMA    = 3'd6;
  localparam logic [2:0] TOK_DOT      = 3'd7;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NUMBER   = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR = 3'd2;
  localparam logic [2:0] ERR_LONE_OP  = 3'd3;
  localparam logic [2:0] ERR_CHAR     = 3'd4;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        byte_value;
    logic [2:0]        token_type;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] column;
    logic [2:0]        error_code;
  } rec_t;

  typedef struct packed {
    logic [REC_CNT_W-1:0]      count;
    rec_t [MAX_RECS-1:0]       recs;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } entry_t;

endpackage

// ===== rtl/exlx_if.sv =====
// ----------------------------------------------------------------------------
// exlx_if
// valid / ready channels for formula bytes and lexer records
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface exlx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface exlx_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  record;
  logic [7:0]                  byte_value;
  logic [2:0]                  token_type;
  logic [exlx_pkg::LINE_W-1:0] line;
  logic [exlx_pkg::LINE_W-1:0] column;
  logic [2:0]                  error_code;
  logic                        last_of_run;

  modport source (
    output valid, output record, output byte_value, output token_type,
    output line, output column, output error_code, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input record, input byte_value, input token_type,
    input line, input column, input error_code, input last_of_run,
    output ready
  );
endinterface

// ===== rtl/exlx_front.sv =====
// ----------------------------------------------------------------------------
// exlx_front
// classifies one formula byte per transfer and builds its record bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exlx_front (
  input  logic            clk,
  input  logic            rst,
  exlx_in_if.sink         in_ch,
  output exlx_pkg::entry_t push,
  input  logic            push_ready
);
  import exlx_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_DOT, M_INT, M_FRAC, M_EXP, M_EXP_SIGN, M_EXP_DIG,
    M_STR, M_STR_ESC, M_IDENT, M_OP
  } mode_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  localparam pos_t POS_ONE = POSITION_BITS'(1);
  localparam pos_t POS_TOP = '1;
  localparam logic [REC_CNT_W-1:0] CNT_ONE = REC_CNT_W'(1);

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_0) && (ch <= CH_9);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] ch);
    return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
           ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || (ch == CH_USCORE);
  endfunction

  function automatic logic is_pair(input logic [7:0] h, input logic [7:0] ch);
    return ((ch == CH_EQ) && (h inside {CH_EQ, CH_BANG, CH_LT, CH_GT})) ||
           ((h == CH_AMP) && (ch == CH_AMP)) || ((h == CH_BAR) && (ch == CH_BAR));
  endfunction

  function automatic rec_t text_rec(input logic [7:0] b);
    rec_t r;
    r = '0;
    r.kind       = REC_TEXT;
    r.byte_value = b;
    r.error_code = ERR_NONE;
    return r;
  endfunction

  function automatic rec_t pos_rec(input logic [1:0] kind, input logic [2:0] tok,
                                   input pos_t ln, input pos_t cl,
                                   input logic [2:0] err);
    rec_t r;
    r = '0;
    r.kind       = kind;
    r.token_type = tok;
    r.line       = LINE_W'(ln);
    r.column     = LINE_W'(cl);
    r.error_code = err;
    return r;
  endfunction

  mode_t      mode;
  logic [7:0] held_char;
  logic       quote_char;
  pos_t       line_count;
  pos_t       column_count;
  pos_t       start_line;
  pos_t       start_column;
  logic       dropping;

  mode_t                mode_next;
  logic [7:0]           held_next;
  logic                 quote_next;
  pos_t                 line_next;
  pos_t                 column_next;
  pos_t                 sline_next;
  pos_t                 scol_next;
  logic                 drop_next;
  bundle_t              bnd;
  logic [REC_CNT_W-1:0] n;
  logic                 do_begin;
  logic [7:0]           c;
  logic                 accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push.valid  = accept && (bnd.count != '0);
  assign push.bundle = bnd;

  always_comb begin
    c           = in_ch.character;
    mode_next   = mode;
    held_next   = held_char;
    quote_next  = quote_char;
    line_next   = line_count;
    column_next = column_count;
    sline_next  = start_line;
    scol_next   = start_column;
    drop_next   = dropping;
    bnd         = '0;
    n           = '0;
    do_begin    = 1'b0;
    if (!dropping) begin
      case (mode)
        M_INT, M_FRAC: begin
          if (is_digit(c)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          end else if ((mode == M_INT) && (c == CH_DOT)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            mode_next = M_FRAC;
          end else if (c inside {CH_LO_E, CH_UP_E}) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            mode_next = M_EXP;
          end else begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_NUMBER, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
            do_begin  = 1'b1;
          end
        end
        M_EXP, M_EXP_SIGN: begin
          if ((mode == M_EXP) && (c inside {CH_PLUS, CH_MINUS})) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            mode_next = M_EXP_SIGN;
          end else if (is_digit(c)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            mode_next = M_EXP_DIG;
          end else begin
            bnd.recs[n] = pos_rec(REC_ERROR, TOK_NUMBER, start_line, start_column,
                                  ERR_NUMBER);
            n = n + CNT_ONE;
            drop_next = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_EXP_DIG: begin
          if (is_digit(c)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          end else begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_NUMBER, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
            do_begin  = 1'b1;
          end
        end
        M_STR: begin
          if (c == (quote_char ? CH_SQUOTE : CH_DQUOTE)) begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_STRING, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_next = M_STR_ESC;
          end else begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          end
        end
        M_STR_ESC: begin
          bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          mode_next = M_STR;
        end
        M_IDENT: begin
          if (is_ident_start(c) || is_digit(c)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          end else begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_IDENT, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
            do_begin  = 1'b1;
          end
        end
        M_DOT: begin
          bnd.recs[n] = text_rec(CH_DOT); n = n + CNT_ONE;
          if (is_digit(c)) begin
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            mode_next = M_FRAC;
          end else begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_DOT, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
            do_begin  = 1'b1;
          end
        end
        M_OP: begin
          if (is_pair(held_char, c)) begin
            bnd.recs[n] = text_rec(held_char); n = n + CNT_ONE;
            bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_OPERATOR, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
          end else if (held_char inside {CH_BANG, CH_LT, CH_GT}) begin
            bnd.recs[n] = text_rec(held_char); n = n + CNT_ONE;
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_OPERATOR, start_line, start_column,
                                  ERR_NONE);
            n = n + CNT_ONE;
            mode_next = M_IDLE;
            do_begin  = 1'b1;
          end else begin
            bnd.recs[n] = pos_rec(REC_ERROR, TOK_NUMBER, start_line, start_column,
                                  ERR_LONE_OP);
            n = n + CNT_ONE;
            drop_next = 1'b1;
            mode_next = M_IDLE;
          end
        end
        default: begin
          mode_next = M_IDLE;
          do_begin  = 1'b1;
        end
      endcase

      // start of a new token
      if (do_begin) begin
        sline_next = line_count;
        scol_next  = column_count;
        if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_NL}) begin
          mode_next = M_IDLE;
        end else if (c inside {CH_LPAREN, CH_RPAREN, CH_COMMA,
                               CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET}) begin
          bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          bnd.recs[n] = pos_rec(REC_TOKEN_END,
                                (c == CH_LPAREN) ? TOK_LPAREN :
                                (c == CH_RPAREN) ? TOK_RPAREN :
                                (c == CH_COMMA)  ? TOK_COMMA  : TOK_OPERATOR,
                                line_count, column_count, ERR_NONE);
          n = n + CNT_ONE;
        end else if (is_digit(c)) begin
          bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          mode_next = M_INT;
        end else if (c == CH_DOT) begin
          mode_next = M_DOT;
        end else if (c inside {CH_DQUOTE, CH_SQUOTE}) begin
          quote_next = (c == CH_SQUOTE);
          mode_next  = M_STR;
        end else if (is_ident_start(c)) begin
          bnd.recs[n] = text_rec(c); n = n + CNT_ONE;
          mode_next = M_IDENT;
        end else if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR}) begin
          held_next = c;
          mode_next = M_OP;
        end else begin
          bnd.recs[n] = pos_rec(REC_ERROR, TOK_NUMBER, line_count, column_count, ERR_CHAR);
          n = n + CNT_ONE;
          drop_next = 1'b1;
          mode_next = M_IDLE;
        end
      end

      // position counters, saturating
      if (c == CH_NL) begin
        if (line_count != POS_TOP) begin
          line_next = line_count + POS_ONE;
        end
        column_next = POS_ONE;
      end else if (column_count != POS_TOP) begin
        column_next = column_count + POS_ONE;
      end

      // close the formula on its final byte
      if (in_ch.last && !drop_next) begin
        case (mode_next)
          M_INT, M_FRAC, M_EXP_DIG, M_IDENT: begin
            bnd.recs[n] = pos_rec(REC_TOKEN_END,
                                  (mode_next == M_IDENT) ? TOK_IDENT : TOK_NUMBER,
                                  sline_next, scol_next, ERR_NONE);
            n = n + CNT_ONE;
          end
          M_EXP, M_EXP_SIGN, M_STR, M_STR_ESC: begin
            bnd.recs[n] = pos_rec(REC_ERROR, TOK_NUMBER, sline_next, scol_next,
                                  (mode_next inside {M_EXP, M_EXP_SIGN}) ?
                                  ERR_NUMBER : ERR_OPEN_STR);
            n = n + CNT_ONE;
            drop_next = 1'b1;
          end
          M_DOT: begin
            bnd.recs[n] = text_rec(CH_DOT); n = n + CNT_ONE;
            bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_DOT, sline_next, scol_next,
                                  ERR_NONE);
            n = n + CNT_ONE;
          end
          M_OP: begin
            if (held_next inside {CH_BANG, CH_LT, CH_GT}) begin
              bnd.recs[n] = text_rec(held_next); n = n + CNT_ONE;
              bnd.recs[n] = pos_rec(REC_TOKEN_END, TOK_OPERATOR, sline_next, scol_next,
                                    ERR_NONE);
              n = n + CNT_ONE;
            end else begin
              bnd.recs[n] = pos_rec(REC_ERROR, TOK_NUMBER, sline_next, scol_next,
                                    ERR_LONE_OP);
              n = n + CNT_ONE;
              drop_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (!drop_next) begin
          bnd.recs[n] = pos_rec(REC_END_INPUT, TOK_NUMBER, line_next, column_next,
                                ERR_NONE);
          n = n + CNT_ONE;
        end
      end
    end
    bnd.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      held_char    <= '0;
      quote_char   <= 1'b0;
      line_count   <= POS_ONE;
      column_count <= POS_ONE;
      start_line   <= POS_ONE;
      start_column <= POS_ONE;
      dropping     <= 1'b0;
    end else if (accept) begin
      if (in_ch.last) begin
        mode         <= M_IDLE;
        held_char    <= '0;
        quote_char   <= 1'b0;
        line_count   <= POS_ONE;
        column_count <= POS_ONE;
        start_line   <= POS_ONE;
        start_column <= POS_ONE;
        dropping     <= 1'b0;
      end else begin
        mode         <= mode_next;
        held_char    <= held_next;
        quote_char   <= quote_next;
        line_count   <= line_next;
        column_count <= column_next;
        start_line   <= sline_next;
        start_column <= scol_next;
        dropping     <= drop_next;
      end
    end
  end

endmodule

// ===== rtl/exlx_queue.sv =====
// ----------------------------------------------------------------------------
// exlx_queue
// short queue of record bundles between classifier and record output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exlx_queue (
  input  logic             clk,
  input  logic             rst,
  input  exlx_pkg::entry_t push,
  output logic             push_ready,
  output exlx_pkg::entry_t head,
  input  logic             pop
);
  import exlx_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  bundle_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready  = (count != CNT_FULL);
  assign do_push     = push.valid && push_ready;
  assign do_pop      = pop && (count != '0);
  assign head.valid  = (count != '0);
  assign head.bundle = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/exlx_back.sv =====
// ----------------------------------------------------------------------------
// exlx_back
// sends the records of each bundle one per transfer through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exlx_back (
  input  logic             clk,
  input  logic             rst,
  input  exlx_pkg::entry_t head,
  output logic             pop,
  exlx_out_if.source       out_ch
);
  import exlx_pkg::*;

  logic [REC_IDX_W-1:0] idx;
  logic                 out_valid;
  rec_t                 out_rec;
  logic                 out_last;
  logic                 is_final;
  logic                 load;

  assign is_final = (idx == REC_IDX_W'(head.bundle.count - REC_CNT_W'(1)));
  assign load     = head.valid && (!out_valid || out_ch.ready);
  assign pop      = load && is_final;

  assign out_ch.valid       = out_valid;
  assign out_ch.record      = out_rec.kind;
  assign out_ch.byte_value  = out_rec.byte_value;
  assign out_ch.token_type  = out_rec.token_type;
  assign out_ch.line        = out_rec.line;
  assign out_ch.column      = out_rec.column;
  assign out_ch.error_code  = out_rec.error_code;
  assign out_ch.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_final ? '0 : idx + REC_IDX_W'(1);
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec  <= head.bundle.recs[idx];
      out_last <= is_final;
    end
  end

endmodule

// ===== rtl/expression_lexer.sv =====
// ----------------------------------------------------------------------------
// expression_lexer
// path: the records of a byte pass the bundle queue and then the output register
// throughput: a byte is taken every cycle while the bundle queue has room;
// records leave one per cycle while the output is ready
// reset: synchronous rst returns lexer state, bundle queue and output register to empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expression_lexer (
  input logic        clk,
  input logic        rst,
  exlx_in_if.sink    in_ch,
  exlx_out_if.source out_ch
);
  import exlx_pkg::*;

  entry_t push;
  logic   push_ready;
  entry_t head;
  logic   pop;

  exlx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  exlx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  exlx_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_bundle_count: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (head.bundle.count != '0 &&
                    head.bundle.count <= REC_CNT_W'(MAX_RECS)))
    else $error("queued bundle with bad record count");

  a_end_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.record == REC_END_INPUT)) |-> out_ch.last_of_run)
    else $error("end of input record not final of its run");

  a_pop_when_full: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop && head.valid) |=> head.valid)
    else $error("queue lost its head bundle");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid right after reset");
`endif

endmodule
